[rtl/core/flfr_pkg.sv]
// ----------------------------------------------------------------------------
// flfr_pkg
// Shared types and constants of the flag/length frame receiver.
// ----------------------------------------------------------------------------
package flfr_pkg;

  localparam int LENGTH_WIDTH = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 17;
  localparam int TOTAL_W      = 17;

  // header length is kept to LENGTH_WIDTH bits
  localparam logic [15:0] LEN_MASK = 16'((32'd1 << LENGTH_WIDTH) - 32'd1);
  localparam logic [TOTAL_W-1:0] FRAME_OVERHEAD = 17'd4;
  localparam logic [TOTAL_W-1:0] MAX_TOTAL_RESET = 17'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_START_FLAG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_FLAG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL  = 2'd2;

  typedef enum logic [1:0] {
    EV_DATA     = 2'd0,
    EV_GOOD     = 2'd1,
    EV_BAD_END  = 2'd2,
    EV_TOO_LONG = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic [7:0]         open_flag;
    logic [7:0]         close_flag;
    logic [TOTAL_W-1:0] max_total;
  } flfr_cfg_t;

  typedef struct packed {
    logic       has;
    ev_kind_t   kind;
    logic [7:0] data;
    logic [15:0] len;
    logic       last;
  } flfr_result_t;

endpackage

[rtl/core/flfr_if.sv]
// ----------------------------------------------------------------------------
// flfr_if
// Valid/ready channels for received bytes and frame events.
// ----------------------------------------------------------------------------
interface flfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface flfr_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  payload_byte;
  logic [15:0] frame_length;
  logic        frame_last;

  modport source (output valid, output event_kind, output payload_byte,
                  output frame_length, output frame_last, input ready);
  modport sink   (input valid, input event_kind, input payload_byte,
                  input frame_length, input frame_last, output ready);
endinterface

[rtl/core/flag_length_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// flag_length_frame_receiver_top
// Cut-through deframer: start flag, 16-bit little-endian length, payload,
// end flag.
// ----------------------------------------------------------------------------
// One byte is accepted every cycle while the event side keeps up. A byte is
// captured in an input register, decoded by the frame state machine when the
// output slot is free or draining, and its event, if any, lands in the output
// register. Payload bytes come out as they arrive; the closing event (good,
// bad end flag, too long) carries the header length and frame_last. Headers,
// hunted bytes and accepted length fields give no event. The user must write
// the configuration through cfg_we/cfg_index/cfg_wdata only while the block
// is idle; the block itself does not enforce this.
module flag_length_frame_receiver_top (
  input  logic                            clk,
  input  logic                            rst_n,
  flfr_byte_if.sink                       in_bus,
  flfr_event_if.source                    out_bus,
  input  logic                            cfg_we,
  input  logic [flfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [flfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import flfr_pkg::*;

  flfr_cfg_t    cfg;
  flfr_result_t res;

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        adv;

  logic        out_valid_r, out_valid_nxt;
  ev_kind_t    out_kind_r;
  logic [7:0]  out_data_r;
  logic [15:0] out_len_r;
  logic        out_last_r;

  flfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  flfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .rx_byte (s1_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  // decode stage moves whenever the output slot is free or draining
  assign adv          = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_bus.ready) s1_valid_nxt = in_bus.valid;
    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = res.has;
    else if (out_bus.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) s1_byte_r <= in_bus.rx_byte;
    if (adv) begin
      out_kind_r <= res.kind;
      out_data_r <= res.data;
      out_len_r  <= res.len;
      out_last_r <= res.last;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.event_kind   = out_kind_r;
  assign out_bus.payload_byte = out_data_r;
  assign out_bus.frame_length = out_len_r;
  assign out_bus.frame_last   = out_last_r;

endmodule

[rtl/core/flfr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// flfr_cfg_regs
// Configuration register file: start flag, end flag, frame size limit.
// ----------------------------------------------------------------------------
module flfr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [flfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [flfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output flfr_pkg::flfr_cfg_t              cfg
);
  import flfr_pkg::*;

  flfr_cfg_t cfg_r;
  flfr_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_FLAG: cfg_nxt.open_flag  = cfg_wdata[7:0];
        CFG_END_FLAG:   cfg_nxt.close_flag = cfg_wdata[7:0];
        CFG_MAX_TOTAL:  cfg_nxt.max_total  = cfg_wdata[TOTAL_W-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_flag  <= 8'd0;
      cfg_r.close_flag <= 8'd0;
      cfg_r.max_total  <= MAX_TOTAL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/flfr_parser.sv]
// ----------------------------------------------------------------------------
// flfr_parser
// Frame state machine: decodes one byte per step and forms the event.
// ----------------------------------------------------------------------------
module flfr_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  input  flfr_pkg::flfr_cfg_t    cfg,
  output flfr_pkg::flfr_result_t res
);
  import flfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_DATA,
    PH_END
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [15:0] frame_len_r, frame_len_nxt;
  logic [LENGTH_WIDTH-1:0] remaining_r, remaining_nxt;
  logic [15:0] hdr_len;
  logic [TOTAL_W-1:0] hdr_total;

  assign hdr_len   = {rx_byte, len_lo_r} & LEN_MASK;
  assign hdr_total = {1'b0, hdr_len} + FRAME_OVERHEAD;

  always_comb begin
    phase_nxt     = phase_r;
    len_lo_nxt    = len_lo_r;
    frame_len_nxt = frame_len_r;
    remaining_nxt = remaining_r;
    res.has  = 1'b0;
    res.kind = EV_DATA;
    res.data = 8'd0;
    res.len  = 16'd0;
    res.last = 1'b0;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == cfg.open_flag) phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_lo_nxt = rx_byte;
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_len_nxt = hdr_len;
        if (hdr_total > cfg.max_total) begin
          phase_nxt = PH_HUNT;
          res.has   = 1'b1;
          res.kind  = EV_TOO_LONG;
          res.len   = hdr_len;
          res.last  = 1'b1;
        end else begin
          remaining_nxt = hdr_len[LENGTH_WIDTH-1:0];
          phase_nxt     = (hdr_len == 16'd0) ? PH_END : PH_DATA;
        end
      end
      PH_DATA: begin
        if (remaining_r != '0) remaining_nxt = remaining_r - LENGTH_WIDTH'(1);
        if (remaining_nxt == '0) phase_nxt = PH_END;
        res.has  = 1'b1;
        res.kind = EV_DATA;
        res.data = rx_byte;
      end
      PH_END: begin
        // failing byte is not re-examined as a start flag
        phase_nxt = PH_HUNT;
        res.has   = 1'b1;
        res.kind  = (rx_byte == cfg.close_flag) ? EV_GOOD : EV_BAD_END;
        res.len   = frame_len_r;
        res.last  = 1'b1;
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      len_lo_r    <= 8'd0;
      frame_len_r <= 16'd0;
      remaining_r <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      len_lo_r    <= len_lo_nxt;
      frame_len_r <= frame_len_nxt;
      remaining_r <= remaining_nxt;
    end
  end

endmodule

[rtl/core/flfr_checker.sv]
// ----------------------------------------------------------------------------
// flfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module flfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_kind,
  input logic [7:0]  payload_byte,
  input logic [15:0] frame_length,
  input logic        frame_last
);
  import flfr_pkg::*;

  // a stalled event beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("event beat dropped while stalled");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (frame_last == (event_kind != EV_DATA)))
    else $error("frame_last does not match event kind");

  a_close_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_last |-> payload_byte == 8'd0)
    else $error("closing event carries payload data");

  a_data_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !frame_last |-> frame_length == 16'd0)
    else $error("payload beat carries a length");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("event offered right after reset");

endmodule

bind flag_length_frame_receiver_top flfr_checker u_flfr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .event_kind   (out_bus.event_kind),
  .payload_byte (out_bus.payload_byte),
  .frame_length (out_bus.frame_length),
  .frame_last   (out_bus.frame_last)
);
